@@ hw/rtl/bgr_pkg.sv @@
package bgr_pkg;

  // Glyph memory depth, a power of two
  localparam int GLYPH_WORDS = 2048;
  localparam int ADDR_W      = $clog2(GLYPH_WORDS);
  localparam int COLOR_BITS  = 16;

  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_CODE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_CODE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOR     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ORIENTATION  = 3'd6;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  typedef struct packed {
    logic              is_draw;
    logic [ADDR_W-1:0] addr;         // load address or glyph base address
    logic [15:0]       wdata;
    logic [4:0]        height;       // saturated, 0..16
    logic [15:0]       full;         // bits 0..width-1
    logic              wide;
    logic              rot;
    logic              mirror;
    logic [3:0]        mshift;       // 8 - width for the mirrored path
    logic              transparent;
    logic [15:0]       ox;
    logic [15:0]       oy;
  } q_entry_t;

endpackage

@@ hw/rtl/bgr_ram.sv @@
module bgr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/bgr_front.sv @@
module bgr_front
  import bgr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  input  logic                  q_ready,
  output logic                  q_push,
  output q_entry_t              q_entry
);

  logic [4:0]  glyph_width_r;
  logic [4:0]  glyph_height_r;
  logic [7:0]  first_code_r;
  logic [7:0]  last_code_r;
  logic [15:0] fg_color_r;
  logic [15:0] bg_color_r;
  logic [1:0]  orientation_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_width_r  <= 5'd4;
      glyph_height_r <= 5'd6;
      first_code_r   <= 8'd32;
      last_code_r    <= 8'd126;
      fg_color_r     <= 16'hFFFF;
      bg_color_r     <= 16'h0000;
      orientation_r  <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_GLYPH_WIDTH:  glyph_width_r  <= cfg_wdata[4:0];
        REG_GLYPH_HEIGHT: glyph_height_r <= cfg_wdata[4:0];
        REG_FIRST_CODE:   first_code_r   <= cfg_wdata[7:0];
        REG_LAST_CODE:    last_code_r    <= cfg_wdata[7:0];
        REG_FG_COLOR:     fg_color_r     <= cfg_wdata[15:0];
        REG_BG_COLOR:     bg_color_r     <= cfg_wdata[15:0];
        REG_ORIENTATION:  orientation_r  <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  logic [10:0] word_index;
  logic [15:0] row_bits;
  logic [7:0]  char_code;
  logic [15:0] origin_x;
  logic [15:0] origin_y;

  assign word_index = in_tdata[10:0];
  assign row_bits   = in_tdata[26:11];
  assign char_code  = in_tdata[34:27];
  assign origin_x   = in_tdata[50:35];
  assign origin_y   = in_tdata[66:51];

  logic [4:0]  w_sat;
  logic [4:0]  h_sat;
  logic [7:0]  code_eff;
  logic [7:0]  code_diff;
  logic [12:0] base_prod;
  logic [16:0] full_ext;
  logic [4:0]  mshift_ext;
  logic        wide;
  logic        rot;

  always_comb begin
    w_sat      = (glyph_width_r > 5'd16) ? 5'd16 : glyph_width_r;
    h_sat      = (glyph_height_r > 5'd16) ? 5'd16 : glyph_height_r;
    code_eff   = (char_code < first_code_r || char_code > last_code_r) ?
                 first_code_r : char_code;
    code_diff  = code_eff - first_code_r;
    base_prod  = 13'(code_diff) * 13'(h_sat);
    full_ext   = (17'd1 << w_sat) - 17'd1;
    wide       = w_sat > 5'd8;
    rot        = !wide && (orientation_r != 2'd0);
    mshift_ext = wide ? 5'd0 : (5'd8 - w_sat);

    q_entry.is_draw     = (in_tuser == CMD_DRAW);
    q_entry.addr        = (in_tuser == CMD_DRAW) ? ADDR_W'(base_prod) : ADDR_W'(word_index);
    q_entry.wdata       = row_bits;
    q_entry.height      = h_sat;
    q_entry.full        = full_ext[15:0];
    q_entry.wide        = wide;
    q_entry.rot         = rot;
    q_entry.mirror      = rot && orientation_r[1];
    q_entry.mshift      = mshift_ext[3:0];
    q_entry.transparent = fg_color_r[COLOR_BITS-1:0] == bg_color_r[COLOR_BITS-1:0];
    q_entry.ox          = origin_x;
    q_entry.oy          = origin_y;
  end

  assign in_tready = q_ready;
  assign q_push    = in_tvalid && q_ready;

endmodule

@@ hw/rtl/bgr_queue.sv @@
module bgr_queue
  import bgr_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     push_ready,
  input  logic     pop,
  output logic     pop_valid,
  output q_entry_t pop_entry
);

  q_entry_t   mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_entry  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_entry;
    end
  end

endmodule

@@ hw/rtl/bgr_back.sv @@
module bgr_back
  import bgr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  q_entry_t               q_entry,
  output logic                   q_pop,
  output logic                   ram_we,
  output logic [ADDR_W-1:0]      ram_waddr,
  output logic [15:0]            ram_wdata,
  output logic [ADDR_W-1:0]      ram_raddr,
  input  logic [15:0]            ram_rdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tuser,
  output logic                   out_tlast
);

  typedef enum logic [1:0] {
    B_IDLE,
    B_READ,
    B_DATA
  } state_t;

  state_t                 state_r,    state_nxt;
  q_entry_t               cur_r,      cur_nxt;
  logic [3:0]             row_r,      row_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;
  logic                   out_user_r, out_user_nxt;
  logic                   out_last_r, out_last_nxt;

  logic [15:0] word_rev;
  logic [7:0]  byte_rev;
  logic [15:0] mirror_bits;
  logic [15:0] fg;
  logic [15:0] dm;
  logic [15:0] line_x;
  logic [15:0] line_y;
  logic        last;

  always_comb begin
    for (int i = 0; i < 16; i++) word_rev[i] = ram_rdata[15-i];
    for (int i = 0; i < 8; i++)  byte_rev[i] = ram_rdata[7-i];
    mirror_bits = {8'd0, ram_rdata[7:0]} >> cur_r.mshift;
    if (cur_r.wide) begin
      fg = word_rev & cur_r.full;
    end else if (cur_r.mirror) begin
      fg = mirror_bits & cur_r.full;
    end else begin
      fg = {8'd0, byte_rev} & cur_r.full;
    end
    dm     = cur_r.transparent ? fg : cur_r.full;
    line_x = cur_r.rot ? cur_r.ox + 16'(row_r) : cur_r.ox;
    line_y = cur_r.rot ? cur_r.oy : cur_r.oy + 16'(row_r);
    last   = {1'b0, row_r} == (cur_r.height - 5'd1);
  end

  assign ram_waddr = q_entry.addr;
  assign ram_wdata = q_entry.wdata;
  assign ram_raddr = cur_r.addr + ADDR_W'(row_r);

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    ram_we        = 1'b0;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          cur_nxt = q_entry;
          row_nxt = 4'd0;
          if (!q_entry.is_draw) begin
            ram_we = 1'b1;
          end else if (q_entry.height != 5'd0) begin
            state_nxt = B_READ;
          end
        end
      end
      B_READ: begin
        state_nxt = B_DATA;
      end
      B_DATA: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {dm, fg, line_y, line_x};
          out_user_nxt  = cur_r.rot;
          out_last_nxt  = last;
          if (last) begin
            state_nxt = B_IDLE;
          end else begin
            row_nxt   = row_r + 4'd1;
            state_nxt = B_READ;
          end
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      row_r       <= 4'd0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      row_r       <= row_nxt;
      cur_r       <= cur_nxt;
      out_data_r  <= out_data_nxt;
      out_user_r  <= out_user_nxt;
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

@@ hw/rtl/bitmap_glyph_rasterizer.sv @@
// Character generator. Load transfers (in_tuser 0) write one glyph row word;
// draw transfers (in_tuser 1) emit one line transfer per glyph row, with
// tlast on the final row. A two-entry queue decouples the input from the
// back end, which handles a load in its idle state and, for each row of a
// draw, runs a registered glyph memory read state, then a formatting state.
// A draw with zero height produces no output. Glyph memory is not cleared
// at reset; rows must be loaded before they are drawn.
module bitmap_glyph_rasterizer
  import bgr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // word_index[10:0], row_bits[26:11], char_code[34:27],
  // origin_x[50:35], origin_y[66:51], zero fill
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // line_x[15:0], line_y[31:16], fg_mask[47:32], draw_mask[63:48]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // vertical
  output logic                   out_tuser,
  // last_line
  output logic                   out_tlast
);

  q_entry_t            push_entry;
  q_entry_t            pop_entry;
  logic                push;
  logic                push_ready;
  logic                pop;
  logic                pop_valid;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr;
  logic [15:0]         ram_wdata;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [15:0]         ram_rdata;

  bgr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_ready   (push_ready),
    .q_push    (push),
    .q_entry   (push_entry)
  );

  bgr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .push_ready (push_ready),
    .pop        (pop),
    .pop_valid  (pop_valid),
    .pop_entry  (pop_entry)
  );

  bgr_ram #(
    .WIDTH (16),
    .DEPTH (GLYPH_WORDS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bgr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (pop_valid),
    .q_entry    (pop_entry),
    .q_pop      (pop),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

@@ hw/rtl/bgr_checker.sv @@
module bgr_checker
  import bgr_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser,
  input logic                   out_tlast
);

  // stalled line transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("output changed while stalled");

  // foreground pixels are always drawn
  a_fg_in_draw: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[47:32] & ~out_tdata[63:48]) == 16'd0)
    else $error("fg_mask outside draw_mask");

  // rotated lines come from the byte path only
  a_vert_narrow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[63:56] == 8'd0 && out_tdata[47:40] == 8'd0)
    else $error("vertical line wider than 8 pixels");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind bitmap_glyph_rasterizer bgr_checker u_chk (.*);

@@ sim/bitmap_glyph_rasterizer_test.sv @@
`timescale 1ns / 100ps

module bitmap_glyph_rasterizer_test;
  import bgr_pkg::*;

  localparam logic [1:0] ORIENT_NORMAL       = 2'd0;
  localparam logic [1:0] ORIENT_ROTATED      = 2'd1;
  localparam logic [1:0] ORIENT_MIRRORED     = 2'd2;
  localparam logic [1:0] ORIENT_MIRRORED_ALT = 2'd3;

  localparam int RANDOM_ITEMS   = 40;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES  = 40;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic signed [15:0] line_x;
    logic signed [15:0] line_y;
    logic               vertical;
    logic [15:0]        fg_mask;
    logic [15:0]        draw_mask;
    logic               last_line;
  } glyph_line_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_idx;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   out_tlast;

  // register shadows
  logic [4:0]  px_per_row;
  logic [4:0]  rows_per_glyph;
  logic [7:0]  code_lo;
  logic [7:0]  code_hi;
  logic [15:0] ink_color;
  logic [15:0] paper_color;
  logic [1:0]  rotate_mode;

  logic [15:0] font_mem [GLYPH_WORDS];
  bit          font_mem_valid [GLYPH_WORDS];

  glyph_line_t pending_lines[$];
  int          line_errors;
  int          items_sent;
  int          burst_left;
  bit          hold_req;

  bitmap_glyph_rasterizer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("bitmap_glyph_rasterizer: mismatch");
    $finish;
  end

  function automatic int glyph_base(input logic [7:0] code, input int h);
    int c;
    c = code;
    if (c < code_lo || c > code_hi) c = code_lo;
    return (c - code_lo) * h;
  endfunction

  function automatic void rasterize_glyph(input logic [7:0] code,
                                          input logic signed [15:0] ox,
                                          input logic signed [15:0] oy);
    int          w, h, base, bitpos;
    bit          wide, rot, mirror, see_through;
    logic [15:0] word, fg, full;
    glyph_line_t ln;
    w = (px_per_row > 16) ? 16 : px_per_row;
    h = (rows_per_glyph > 16) ? 16 : rows_per_glyph;
    base = glyph_base(code, h);
    wide = w > 8;
    rot = !wide && rotate_mode != ORIENT_NORMAL;
    mirror = rot && (rotate_mode == ORIENT_MIRRORED || rotate_mode == ORIENT_MIRRORED_ALT);
    see_through = ink_color == paper_color;
    full = 16'((32'd1 << w) - 1);
    for (int r = 0; r < h; r++) begin
      word = font_mem[(base + r) % GLYPH_WORDS];
      fg = '0;
      for (int i = 0; i < w; i++) begin
        if (wide) bitpos = 15 - i;
        else if (mirror) bitpos = 8 - w + i;
        else bitpos = 7 - i;
        fg[i] = word[bitpos];
      end
      if (rot) begin
        ln.line_x = 16'(ox + r);
        ln.line_y = oy;
        ln.vertical = 1'b1;
      end else begin
        ln.line_x = ox;
        ln.line_y = 16'(oy + r);
        ln.vertical = 1'b0;
      end
      ln.fg_mask = fg;
      ln.draw_mask = see_through ? fg : full;
      ln.last_line = (r + 1 == h);
      pending_lines.push_back(ln);
    end
  endfunction

  // one input transfer; model updated at the accepting edge
  task automatic send_item(input logic cmd, input logic [10:0] idx,
                           input logic [15:0] bits, input logic [7:0] code,
                           input logic signed [15:0] ox, input logic signed [15:0] oy);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {5'b0, oy, ox, code, bits, idx};
    do @(posedge clk); while (!in_tready);
    if (cmd == CMD_LOAD) begin
      font_mem[idx] = bits;
      font_mem_valid[idx] = 1'b1;
    end else begin
      rasterize_glyph(code, ox, oy);
    end
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic load_row(input int addr, input logic [15:0] bits);
    send_item(CMD_LOAD, 11'(addr), bits, 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  // rows the glyph needs are loaded first so nothing unwritten is read
  task automatic draw_char(input logic [7:0] code, input logic signed [15:0] ox,
                           input logic signed [15:0] oy);
    int h, base, addr;
    h = (rows_per_glyph > 16) ? 16 : rows_per_glyph;
    base = glyph_base(code, h);
    for (int r = 0; r < h; r++) begin
      addr = (base + r) % GLYPH_WORDS;
      if (!font_mem_valid[addr]) load_row(addr, 16'($urandom));
    end
    send_item(CMD_DRAW, 11'($urandom), 16'($urandom), code, ox, oy);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_GLYPH_WIDTH:  px_per_row = value[4:0];
      REG_GLYPH_HEIGHT: rows_per_glyph = value[4:0];
      REG_FIRST_CODE:   code_lo = value[7:0];
      REG_LAST_CODE:    code_hi = value[7:0];
      REG_FG_COLOR:     ink_color = value;
      REG_BG_COLOR:     paper_color = value;
      REG_ORIENTATION:  rotate_mode = value[1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int w, input int h, input int lo, input int hi,
                           input logic [15:0] ink, input logic [15:0] paper,
                           input logic [1:0] orient);
    wait_idle();
    write_reg(REG_GLYPH_WIDTH, 16'(w));
    write_reg(REG_GLYPH_HEIGHT, 16'(h));
    write_reg(REG_FIRST_CODE, 16'(lo));
    write_reg(REG_LAST_CODE, 16'(hi));
    write_reg(REG_FG_COLOR, ink);
    write_reg(REG_BG_COLOR, paper);
    write_reg(REG_ORIENTATION, 16'(orient));
    cfg_we <= 1'b0;
  endtask

  task automatic test_reset_config();
    int base;
    base = glyph_base(8'h41, 6);
    load_row(base, 16'hFFFF);
    load_row(base + 1, 16'h0000);
    load_row(base + 2, 16'h00A5);
    load_row(base + 3, 16'hFF5A);
    load_row(base + 4, 16'h0080);
    load_row(base + 5, 16'h0001);
    draw_char(8'h41, 16'sd10, 16'sd20);
    draw_char(8'h00, 16'sd0, -16'sd1);
    draw_char(8'hFF, 16'h7FFF, 16'h8000);
  endtask

  task automatic test_orientations();
    configure(8, 3, 32, 126, 16'hFFFF, 16'h0000, ORIENT_ROTATED);
    draw_char(8'h41, 16'h7FFE, 16'sd5);
    configure(8, 3, 32, 126, 16'hFFFF, 16'h0000, ORIENT_MIRRORED);
    draw_char(8'h41, 16'sd3, 16'sd4);
    configure(5, 3, 32, 126, 16'hFFFF, 16'h0000, ORIENT_MIRRORED_ALT);
    draw_char(8'h42, -16'sd2, 16'sd7);
  endtask

  task automatic test_width_extremes();
    configure(0, 2, 32, 126, 16'h0000, 16'hFFFF, ORIENT_ROTATED);
    draw_char(8'h41, 16'sd1, 16'sd1);
    configure(1, 2, 32, 126, 16'h0000, 16'hFFFF, ORIENT_MIRRORED);
    draw_char(8'h41, 16'sd1, 16'sd1);
    configure(9, 2, 32, 126, 16'h0000, 16'hFFFF, ORIENT_ROTATED);
    draw_char(8'h43, 16'sd1, 16'sd1);
    configure(31, 2, 32, 126, 16'h1234, 16'h4321, ORIENT_NORMAL);
    draw_char(8'h43, 16'sd1, 16'sd1);
  endtask

  task automatic test_height_and_codes();
    configure(8, 0, 32, 126, 16'hFFFF, 16'h0000, ORIENT_NORMAL);
    draw_char(8'h41, 16'sd0, 16'sd0);
    configure(16, 31, 0, 255, 16'h5555, 16'h5555, ORIENT_NORMAL);
    draw_char(8'hFF, 16'sd0, 16'h7FF8);
    draw_char(8'h00, 16'sd0, 16'sd0);
    configure(8, 1, 200, 100, 16'hFFFF, 16'hFFFF, ORIENT_ROTATED);
    draw_char(8'd150, 16'hFFFF, 16'h8000);
  endtask

  task automatic test_backpressure();
    configure(8, 16, 32, 126, 16'hF000, 16'h000F, ORIENT_NORMAL);
    draw_char(8'h50, 16'sd0, 16'sd0);
    wait_idle();
    hold_req = 1'b1;
    repeat (6) draw_char(8'h50, 16'($urandom), 16'($urandom));
  endtask

  task automatic random_config();
    int          w, h, lo, hi;
    logic [15:0] ink, paper;
    case ($urandom_range(0, 7))
      0: w = 0;
      1: w = 1;
      2: w = 8;
      3: w = 9;
      4: w = 16;
      5: w = $urandom_range(17, 31);
      default: w = $urandom_range(1, 16);
    endcase
    case ($urandom_range(0, 7))
      0: h = 0;
      1: h = 16;
      2: h = $urandom_range(17, 31);
      default: h = $urandom_range(1, 8);
    endcase
    case ($urandom_range(0, 5))
      0: begin
        lo = 0;
        hi = 255;
      end
      1: begin
        lo = $urandom_range(1, 255);
        hi = $urandom_range(0, lo - 1);
      end
      default: begin
        lo = $urandom_range(0, 255);
        hi = $urandom_range(lo, 255);
      end
    endcase
    ink = 16'($urandom);
    paper = ($urandom_range(0, 2) == 0) ? ink : 16'($urandom);
    configure(w, h, lo, hi, ink, paper, 2'($urandom_range(0, 3)));
  endtask

  task automatic test_random_traffic();
    int                 start, phase_start;
    logic [7:0]         code;
    logic signed [15:0] ox, oy;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      random_config();
      phase_start = items_sent;
      while (items_sent - phase_start < 20) begin
        if ($urandom_range(0, 9) == 0) begin
          load_row($urandom_range(0, GLYPH_WORDS - 1), 16'($urandom));
        end else begin
          case ($urandom_range(0, 5))
            0: code = code_lo;
            1: code = code_hi;
            2: code = 8'($urandom);
            default: code = (code_lo <= code_hi) ?
                            8'($urandom_range(code_lo, code_hi)) : 8'($urandom);
          endcase
          ox = ($urandom_range(0, 7) == 0) ? 16'h7FFF : 16'($urandom);
          oy = ($urandom_range(0, 7) == 0) ? 16'h8000 : 16'($urandom);
          draw_char(code, ox, oy);
        end
      end
    end
  endtask

  // receiver stall pattern, with a long hold when requested
  initial begin
    int seg_left, mode, hold_left;
    out_tready <= 1'b0;
    seg_left = 0;
    mode = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = RX_HOLD_CYCLES;
      end
      if (seg_left == 0) begin
        mode = $urandom_range(0, 3);
        seg_left = $urandom_range(8, 64);
      end
      seg_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= ($urandom_range(0, 7) != 0);
          default: out_tready <= (seg_left % 3 != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin : line_check
    glyph_line_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.line_x    = out_tdata[15:0];
      got.line_y    = out_tdata[31:16];
      got.fg_mask   = out_tdata[47:32];
      got.draw_mask = out_tdata[63:48];
      got.vertical  = out_tuser;
      got.last_line = out_tlast;
      if (pending_lines.size() == 0) begin
        line_errors++;
        if (line_errors <= MAX_REPORTS)
          $display("unexpected line transfer: x=%h y=%h v=%b fg=%h dm=%h last=%b",
                   got.line_x, got.line_y, got.vertical, got.fg_mask,
                   got.draw_mask, got.last_line);
      end else begin
        want = pending_lines.pop_front();
        if (got !== want) begin
          line_errors++;
          if (line_errors <= MAX_REPORTS) begin
            $display("line mismatch: exp x=%h y=%h v=%b fg=%h dm=%h last=%b",
                     want.line_x, want.line_y, want.vertical, want.fg_mask,
                     want.draw_mask, want.last_line);
            $display("               got x=%h y=%h v=%b fg=%h dm=%h last=%b",
                     got.line_x, got.line_y, got.vertical, got.fg_mask,
                     got.draw_mask, got.last_line);
          end
        end
      end
    end
  end

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= CMD_LOAD;
    px_per_row     = 5'd4;
    rows_per_glyph = 5'd6;
    code_lo        = 8'd32;
    code_hi        = 8'd126;
    ink_color      = 16'hFFFF;
    paper_color    = 16'h0000;
    rotate_mode    = ORIENT_NORMAL;
    line_errors = 0;
    items_sent = 0;
    hold_req = 1'b0;
    burst_left = $urandom_range(1, 24);
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_config();
    test_orientations();
    test_width_extremes();
    test_height_and_codes();
    test_backpressure();
    test_random_traffic();
    wait_idle();
    if (line_errors == 0) begin
      $display("bitmap_glyph_rasterizer: match");
    end else begin
      $display("bitmap_glyph_rasterizer: mismatch");
    end
    $finish;
  end

endmodule

@@ bitmap_glyph_rasterizer.f @@
hw/rtl/bgr_pkg.sv
hw/rtl/bgr_ram.sv
hw/rtl/bgr_front.sv
hw/rtl/bgr_queue.sv
hw/rtl/bgr_back.sv
hw/rtl/bitmap_glyph_rasterizer.sv
hw/rtl/bgr_checker.sv
sim/bitmap_glyph_rasterizer_test.sv
